/* rtl/core/eds_pkg.sv */
// ----------------------------------------------------------------------------
// eds_pkg
// Shared types, register codes and the tangent table builder of the
// electronic differential speed split.
// ----------------------------------------------------------------------------
`default_nettype none

package eds_pkg;

  // Steering magnitude at which the tangent table ends.
  localparam int STEER_MAX_DEF = 1440;

  localparam int ANGLE_W = 12;
  localparam int SPEED_W = 16;
  localparam int GAIN_W  = 16;
  localparam int DBAND_W = 11;
  localparam int TAN_W   = 18;  // Q0.16 tangent, room for values up to 4.0
  localparam int PG_W    = SPEED_W + GAIN_W;
  localparam int PROD_W  = PG_W + TAN_W;
  localparam int PROD_SH = 28;
  localparam int DMAG_W  = PROD_W - PROD_SH;
  localparam int MAG_W   = ANGLE_W + 1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [GAIN_W-1:0]  DIFF_GAIN_RST = 16'd4096;
  localparam logic [DBAND_W-1:0] DEADBAND_RST  = 11'd40;
  localparam logic [SPEED_W-1:0] MAX_DELTA_RST = 16'hFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIFF_GAIN = 2'd0,
    REG_DEADBAND  = 2'd1,
    REG_MAX_DELTA = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [GAIN_W-1:0]  diff_gain;
    logic [DBAND_W-1:0] deadband;
    logic [SPEED_W-1:0] max_delta;
  } eds_cfg_t;

  // Fixed-point constants of the table builder (Q60).
  localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
  localparam logic [63:0] ONE_Q60 = 64'h1000000000000000;
  localparam logic [63:0] TAN_K   = (PI_Q60 / 64'd72000) * 64'd7 +
                                    ((PI_Q60 % 64'd72000) * 64'd7) / 64'd72000;

  // (a * b) >> 60 for operands below 2^62.
  function automatic logic [63:0] mul60(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] ah, al, bh, bl, mid;
    ah  = a >> 30;
    al  = a & 64'h3FFFFFFF;
    bh  = b >> 30;
    bl  = b & 64'h3FFFFFFF;
    mid = ah * bl + al * bh + ((al * bl) >> 30);
    return ah * bh + (mid >> 30);
  endfunction

  // Restoring division, used only while the table is built.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Q0.16 tangent of the wheel angle for a steering magnitude m in 1/8 degree.
  function automatic logic [TAN_W-1:0] tan_q16(input logic [ANGLE_W-1:0] m);
    logic [63:0] x, s, c, ts, tc, n, s40, c40, q17;
    if (m == '0) begin
      return '0;
    end
    x  = 64'(m) * TAN_K;
    s  = x;
    ts = x;
    c  = ONE_Q60;
    tc = ONE_Q60;
    for (int i = 1; i <= 12; i++) begin
      n  = 64'(2 * i);
      ts = udiv64(mul60(mul60(ts, x), x), n * (n + 64'd1));
      tc = udiv64(mul60(mul60(tc, x), x), (n - 64'd1) * n);
      if ((i % 2) == 1) begin
        s = s - ts;
        c = c - tc;
      end else begin
        s = s + ts;
        c = c + tc;
      end
    end
    s40 = s >> 20;
    c40 = c >> 20;
    if (c40 == '0) begin
      return '0;
    end
    q17 = udiv64(s40 << 17, c40);
    return TAN_W'((q17 + 64'd1) >> 1);
  endfunction

endpackage

`default_nettype wire

/* rtl/core/eds_cfg_regs.sv */
// ----------------------------------------------------------------------------
// eds_cfg_regs
// Configuration register file: gain, deadband and delta limit.
// ----------------------------------------------------------------------------
`default_nettype none

module eds_cfg_regs (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               wr_en,
  input  wire logic [eds_pkg::CFG_IDX_W-1:0]      wr_index,
  input  wire logic [eds_pkg::CFG_DATA_W-1:0]     wr_data,
  output eds_pkg::eds_cfg_t                       cfg
);

  eds_pkg::eds_cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        eds_pkg::REG_DIFF_GAIN: cfg_nxt.diff_gain = wr_data[eds_pkg::GAIN_W-1:0];
        eds_pkg::REG_DEADBAND:  cfg_nxt.deadband  = wr_data[eds_pkg::DBAND_W-1:0];
        eds_pkg::REG_MAX_DELTA: cfg_nxt.max_delta = wr_data[eds_pkg::SPEED_W-1:0];
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.diff_gain <= eds_pkg::DIFF_GAIN_RST;
      cfg_r.deadband  <= eds_pkg::DEADBAND_RST;
      cfg_r.max_delta <= eds_pkg::MAX_DELTA_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

/* rtl/core/eds_tan_rom.sv */
// ----------------------------------------------------------------------------
// eds_tan_rom
// Wheel angle tangent ROM, Q0.16, indexed by steering magnitude, with a
// registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module eds_tan_rom #(
  parameter int STEER_MAX = eds_pkg::STEER_MAX_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rd_en,
  input  wire logic [$clog2(STEER_MAX+1)-1:0]    rd_addr,
  output logic      [eds_pkg::TAN_W-1:0]         rd_data
);

  localparam int DEPTH = STEER_MAX + 1;

  typedef logic [eds_pkg::TAN_W-1:0] tan_rom_t [DEPTH];

  function automatic tan_rom_t build_rom();
    tan_rom_t rom;
    for (int m = 0; m < DEPTH; m++) begin
      rom[m] = eds_pkg::tan_q16(eds_pkg::ANGLE_W'(m));
    end
    return rom;
  endfunction

  localparam tan_rom_t TAN_ROM = build_rom();

  logic [eds_pkg::TAN_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= TAN_ROM[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* rtl/core/eds_wheel_mix.sv */
// ----------------------------------------------------------------------------
// eds_wheel_mix
// Output stage: clamps the speed delta and forms the saturated left and
// right wheel speeds in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module eds_wheel_mix (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  input  wire logic                            in_neg,
  input  wire logic [eds_pkg::SPEED_W-1:0]     in_pedal,
  input  wire logic [eds_pkg::DMAG_W-1:0]      in_dmag,
  input  wire logic [eds_pkg::SPEED_W-1:0]     max_delta,
  output logic                                 in_ready,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [eds_pkg::SPEED_W-1:0]     out_left,
  output logic      [eds_pkg::SPEED_W-1:0]     out_right
);

  localparam int SW = eds_pkg::SPEED_W;

  logic          valid_r;
  logic [SW-1:0] left_r, right_r, left_nxt, right_nxt;
  logic [SW-1:0] delta;
  logic [SW:0]   sum;
  logic [SW-1:0] up, down;

  always_comb begin
    if (in_dmag > eds_pkg::DMAG_W'(max_delta)) begin
      delta = max_delta;
    end else begin
      delta = in_dmag[SW-1:0];
    end
    sum  = {1'b0, in_pedal} + {1'b0, delta};
    up   = sum[SW] ? '1 : sum[SW-1:0];
    down = (delta > in_pedal) ? '0 : in_pedal - delta;
    // A left turn (negative angle) speeds up the right wheel.
    left_nxt  = in_neg ? down : up;
    right_nxt = in_neg ? up : down;
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      left_r  <= left_nxt;
      right_r <= right_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_left  = left_r;
  assign out_right = right_r;

endmodule

`default_nettype wire

/* rtl/core/electronic_differential_speed_split.sv */
// ----------------------------------------------------------------------------
// electronic_differential_speed_split
// Open-loop electronic differential: splits a pedal speed reference into
// left and right wheel speed references from the steering angle.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ stream carries one word per sample: steering angle (signed,
//   1/8 degree) and pedal speed. The out_ stream returns one word per input
//   word: left and right wheel speed, saturated to 0..65535.
//   The cfg_ channel writes gain, deadband and delta limit; cfg_ready is
//   always high. Write configuration only while no word is in flight.
//   The datapath is a four stage pipeline: angle conditioning, tangent ROM
//   read with pedal-times-gain multiply, 32x18 product, then delta clamp and
//   wheel saturation into the output register. An accepted word passes the
//   stage 1, 2 and 3 registers and the output register before out_tvalid
//   rises; throughput is one word per cycle while out_tready stays high.
//   When the receiver stalls, each stage holds its word and stages with a
//   bubble keep filling, so up to four words are taken before in_tready
//   drops. Reset clears all stage valid bits and restores the register
//   defaults (gain 1.0, deadband 5 degrees, no delta limit).
// ----------------------------------------------------------------------------
`default_nettype none

module electronic_differential_speed_split #(
  parameter int STEER_MAX = eds_pkg::STEER_MAX_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // [11:0] steering_angle, [27:12] pedal_speed, [31:28] zero
  input  wire logic [31:0]                         in_tdata,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // [15:0] left_speed, [31:16] right_speed
  output logic      [31:0]                         out_tdata,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [eds_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [eds_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int IDX_W  = $clog2(STEER_MAX + 1);
  localparam int AW     = eds_pkg::ANGLE_W;
  localparam int MW     = eds_pkg::MAG_W;
  localparam int SW     = eds_pkg::SPEED_W;
  localparam int PG_W   = eds_pkg::PG_W;
  localparam int PROD_W = eds_pkg::PROD_W;
  localparam int DMAG_W = eds_pkg::DMAG_W;

  eds_pkg::eds_cfg_t cfg;

  assign cfg_ready = 1'b1;

  eds_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Stage 1: steering magnitude, deadband and range saturation.
  logic [AW-1:0] angle;
  logic [SW-1:0] pedal;
  logic          neg;
  logic [MW-1:0] mag, mag_sat;

  assign angle = in_tdata[AW-1:0];
  assign pedal = in_tdata[AW+SW-1:AW];
  assign neg   = angle[AW-1];

  always_comb begin
    mag = neg ? (MW'(1) << AW) - {1'b0, angle} : {1'b0, angle};
    if (mag < MW'(cfg.deadband)) begin
      mag_sat = '0;
    end else if (mag > MW'(STEER_MAX)) begin
      mag_sat = MW'(STEER_MAX);
    end else begin
      mag_sat = mag;
    end
  end

  logic             v1_r, v2_r, v3_r;
  logic             neg1_r, neg2_r, neg3_r;
  logic [SW-1:0]    pedal1_r, pedal2_r, pedal3_r;
  logic [IDX_W-1:0] idx1_r;
  logic [PG_W-1:0]  pg2_r;
  logic [eds_pkg::TAN_W-1:0] tan2;
  logic [PROD_W-1:0]  prod;
  logic [DMAG_W-1:0]  dmag3_r;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy3      = !v3_r || rdy4;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_tvalid) begin
      neg1_r   <= neg;
      pedal1_r <= pedal;
      idx1_r   <= mag_sat[IDX_W-1:0];
    end
  end

  // Stage 2: tangent lookup alongside pedal times gain.
  eds_tan_rom #(
    .STEER_MAX (STEER_MAX)
  ) u_tan_rom (
    .clk     (clk),
    .rd_en   (rdy2 && v1_r),
    .rd_addr (idx1_r),
    .rd_data (tan2)
  );

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      neg2_r   <= neg1_r;
      pedal2_r <= pedal1_r;
      pg2_r    <= PG_W'(pedal1_r) * PG_W'(cfg.diff_gain);
    end
  end

  // Stage 3: full Q28 product, truncated to the delta magnitude.
  assign prod = PROD_W'(pg2_r) * PROD_W'(tan2);

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      neg3_r   <= neg2_r;
      pedal3_r <= pedal2_r;
      dmag3_r  <= prod[PROD_W-1:eds_pkg::PROD_SH];
    end
  end

  // Stage 4: clamp and wheel saturation into the output register.
  logic [SW-1:0] left, right;

  eds_wheel_mix u_mix (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v3_r),
    .in_neg    (neg3_r),
    .in_pedal  (pedal3_r),
    .in_dmag   (dmag3_r),
    .max_delta (cfg.max_delta),
    .in_ready  (rdy4),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_left  (left),
    .out_right (right)
  );

  assign out_tdata = {right, left};

endmodule

`default_nettype wire

/* rtl/core/eds_checker.sv */
// ----------------------------------------------------------------------------
// eds_checker
// Port-level checks of the speed split: stall behavior, reset and the
// straight-ahead case.
// ----------------------------------------------------------------------------
`default_nettype none

module eds_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [31:0] in_tdata,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata
);

  // A stalled result word stays and holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output word changed");

  // The input side only backs up when the output is stalled.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without an output stall");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output word present after reset");

  // A centered wheel with a free receiver gives equal wheel speeds once the
  // word reaches the output register.
  a_straight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tdata[11:0] == 12'd0)) ##1 out_tready
      ##1 out_tready ##1 out_tready
      |=> out_tvalid && (out_tdata[15:0] == out_tdata[31:16]))
    else $error("straight-ahead word gave unequal wheel speeds");

endmodule

bind electronic_differential_speed_split eds_checker u_eds_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

/* sim/wheel_speed_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wheel_speed_checker
// Watches the sample, result and register channels of the speed split,
// predicts left and right wheel speeds for every accepted sample and
// compares them in order with the words that leave the block.
// ----------------------------------------------------------------------------

module wheel_speed_checker #(
  parameter int STEER_LIMIT = eds_pkg::STEER_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [31:0]                     in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [31:0]                     out_tdata,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [eds_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [eds_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              error_count,
  output int                              pending
);
  import eds_pkg::*;

  localparam logic [63:0] HALF_TURN_Q60 = 64'h3243F6A8885A308D;
  localparam logic [63:0] UNIT_Q60      = 64'h1000000000000000;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    logic [SPEED_W-1:0] pedal;
    logic [SPEED_W-1:0] left;
    logic [SPEED_W-1:0] right;
  } wheel_pair_t;

  logic [TAN_W-1:0]   tan_rom [0:STEER_LIMIT];
  logic [GAIN_W-1:0]  gain_q12;
  logic [DBAND_W-1:0] dead_zone;
  logic [SPEED_W-1:0] delta_limit;
  wheel_pair_t        wheel_q[$];

  function automatic logic [63:0] q60_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] full;
    full = {64'd0, a} * {64'd0, b};
    return full[123:60];
  endfunction

  // Wheel angle tangent in Q0.16 from Taylor series of sine and cosine in Q60.
  function automatic logic [63:0] wheel_tan_q16(input int unsigned m);
    logic [63:0] rad_step, x, sin_acc, cos_acc, sin_term, cos_term, n, q17;
    if (m == 0) begin
      return 64'd0;
    end
    rad_step = (HALF_TURN_Q60 / 64'd72000) * 64'd7 +
               ((HALF_TURN_Q60 % 64'd72000) * 64'd7) / 64'd72000;
    x        = 64'(m) * rad_step;
    sin_acc  = x;
    sin_term = x;
    cos_acc  = UNIT_Q60;
    cos_term = UNIT_Q60;
    for (int i = 1; i <= 12; i++) begin
      n        = 64'(2 * i);
      sin_term = q60_mul(q60_mul(sin_term, x), x) / (n * (n + 64'd1));
      cos_term = q60_mul(q60_mul(cos_term, x), x) / ((n - 64'd1) * n);
      if (i % 2 == 1) begin
        sin_acc = sin_acc - sin_term;
        cos_acc = cos_acc - cos_term;
      end else begin
        sin_acc = sin_acc + sin_term;
        cos_acc = cos_acc + cos_term;
      end
    end
    if ((cos_acc >> 20) == 64'd0) begin
      return 64'd0;
    end
    q17 = ((sin_acc >> 20) << 17) / (cos_acc >> 20);
    return (q17 + 64'd1) >> 1;
  endfunction

  function automatic wheel_pair_t predict_wheels(input logic [ANGLE_W-1:0] angle,
                                                 input logic [SPEED_W-1:0] pedal);
    logic               turn_left;
    logic [MAG_W-1:0]   mag;
    logic [63:0]        dmag;
    logic [SPEED_W:0]   sum;
    logic [SPEED_W-1:0] fast, slow;
    wheel_pair_t        r;
    turn_left = angle[ANGLE_W-1];
    mag = turn_left ? (13'h1000 - {1'b0, angle}) : {1'b0, angle};
    if (mag < dead_zone) begin
      mag = '0;
    end
    if (mag > STEER_LIMIT) begin
      mag = MAG_W'(STEER_LIMIT);
    end
    dmag = (64'(pedal) * 64'(gain_q12) * 64'(tan_rom[mag])) >> 28;
    if (dmag > 64'(delta_limit)) begin
      dmag = 64'(delta_limit);
    end
    sum  = {1'b0, pedal} + {1'b0, dmag[SPEED_W-1:0]};
    fast = sum[SPEED_W] ? 16'hFFFF : sum[SPEED_W-1:0];
    slow = (dmag > 64'(pedal)) ? 16'd0 : pedal - dmag[SPEED_W-1:0];
    r.angle = angle;
    r.pedal = pedal;
    // A positive angle speeds up the left wheel.
    r.left  = turn_left ? slow : fast;
    r.right = turn_left ? fast : slow;
    return r;
  endfunction

  task automatic report(input string field, input wheel_pair_t want,
                        input logic [SPEED_W-1:0] exp_v, input logic [SPEED_W-1:0] got_v);
    error_count++;
    if (error_count <= 10) begin
      $display("%0t: %s mismatch for angle %0d pedal %0d: expected %0d, got %0d",
               $time, field, $signed(want.angle), want.pedal, exp_v, got_v);
    end
  endtask

  initial begin
    error_count = 0;
    pending     = 0;
    for (int m = 0; m <= STEER_LIMIT; m++) begin
      tan_rom[m] = TAN_W'(wheel_tan_q16(m));
    end
  end

  always @(posedge clk) begin
    wheel_pair_t want;
    logic [SPEED_W-1:0] got_left, got_right;
    if (!rst_n) begin
      gain_q12    = DIFF_GAIN_RST;
      dead_zone   = DEADBAND_RST;
      delta_limit = MAX_DELTA_RST;
      wheel_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got_left  = out_tdata[15:0];
        got_right = out_tdata[31:16];
        if (wheel_q.size() == 0) begin
          error_count++;
          if (error_count <= 10) begin
            $display("%0t: word with nothing pending: left %0d right %0d",
                     $time, got_left, got_right);
          end
        end else begin
          want = wheel_q.pop_front();
          if (got_left !== want.left) begin
            report("left_speed", want, want.left, got_left);
          end
          if (got_right !== want.right) begin
            report("right_speed", want, want.right, got_right);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        wheel_q.push_back(predict_wheels(in_tdata[11:0], in_tdata[27:12]));
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DIFF_GAIN: gain_q12    = cfg_data[GAIN_W-1:0];
          REG_DEADBAND:  dead_zone   = cfg_data[DBAND_W-1:0];
          REG_MAX_DELTA: delta_limit = cfg_data[SPEED_W-1:0];
          default: ;
        endcase
      end
    end
    pending = wheel_q.size();
  end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives steering and pedal samples and register writes into the speed
// split under several idle and stall mixes, including long receiver
// hold-offs, and reports the verdict from the checker's error count.
// ----------------------------------------------------------------------------

module tb;
  import eds_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int RAND_PER_BLOCK = 69;
  localparam int LONG_HOLD      = 60;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [31:0]           in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [31:0]           out_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    error_count;
  int                    pending;

  int                    idle_pct = 0;
  int                    stall_pct = 0;
  int                    holds_asked = 0;
  int                    holds_done = 0;
  int                    dead_now = 40;

  always #5 clk = ~clk;

  electronic_differential_speed_split dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  wheel_speed_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .error_count (error_count),
    .pending     (pending)
  );

  // Receiver: random stalls, plus a long hold-off whenever one is asked for.
  initial begin
    int hold_left;
    hold_left  = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (holds_done != holds_asked) begin
        out_tready <= 1'b0;
        hold_left = LONG_HOLD - 1;
        holds_done++;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  task automatic send_word(input int angle, input logic [SPEED_W-1:0] pedal);
    @(negedge clk);
    while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'd0, pedal, 12'(angle)};
    do @(posedge clk); while (!in_tready);
  endtask

  // Lets every pending word drain so the registers can be changed safely.
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_DEADBAND) begin
      dead_now = int'(value);
    end
  endtask

  task automatic set_regs(input int gain, input int dead, input int limit);
    settle();
    cfg_write(REG_DIFF_GAIN, 16'(gain));
    cfg_write(REG_DEADBAND, 16'(dead));
    cfg_write(REG_MAX_DELTA, 16'(limit));
  endtask

  function automatic logic [ANGLE_W-1:0] pick_angle();
    int unsigned sel;
    int a;
    sel = $urandom_range(0, 99);
    if (sel < 50) begin
      a = $urandom_range(0, 2880) - 1440;
    end else if (sel < 65) begin
      return 12'($urandom);
    end else if (sel < 80) begin
      // Straddle the deadband edge on either side of center.
      a = dead_now + $urandom_range(0, 4) - 2;
      if ($urandom_range(0, 1) == 1) begin
        a = -a;
      end
    end else if (sel < 90) begin
      case ($urandom_range(0, 3))
        0:       a = 1440;
        1:       a = -1440;
        2:       a = 2047;
        default: a = -2048;
      endcase
    end else begin
      a = $urandom_range(0, 6) - 3;
    end
    return 12'(a);
  endfunction

  function automatic logic [SPEED_W-1:0] pick_pedal();
    case ($urandom_range(0, 4))
      0:       return 16'($urandom_range(0, 255));
      1:       return 16'($urandom_range(65280, 65535));
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_DIFF_GAIN;
    cfg_data  = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Register defaults: deadband edges, range limits and wheel overflow.
    send_word(0, 16'd0);
    send_word(1440, 16'hFFFF);
    send_word(-1440, 16'hFFFF);
    send_word(2047, 16'd30000);
    send_word(-2048, 16'd30000);
    send_word(39, 16'd1000);
    send_word(40, 16'd1000);
    send_word(-39, 16'd1000);
    send_word(-40, 16'd1000);

    // Full gain, no deadband: underflow and a delta beyond any wheel range.
    set_regs(65535, 0, 65535);
    send_word(1, 16'hFFFF);
    send_word(-1440, 16'd1000);
    send_word(1440, 16'hFFFF);
    send_word(-1, 16'h5555);
    send_word(2047, 16'hAAAA);
    settle();
    cfg_write(REG_UNUSED, 16'h0000);
    send_word(720, 16'd20000);

    // Zero gain with the widest deadband.
    set_regs(0, 1440, 0);
    send_word(1439, 16'd40000);
    send_word(1440, 16'd40000);
    send_word(-1440, 16'd40000);

    // Delta limit at zero, then a small one.
    set_regs(65535, 0, 0);
    send_word(1440, 16'd30000);
    settle();
    cfg_write(REG_MAX_DELTA, 16'd300);
    send_word(-1440, 16'd50000);
    send_word(1440, 16'd65500);

    for (int blk = 0; blk < 8; blk++) begin
      settle();
      case (blk / 2)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 52; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 52; end
        default: begin idle_pct = 20; stall_pct = 20; end
      endcase
      case ($urandom_range(0, 3))
        0: set_regs(4096, $urandom_range(0, 80), 65535);
        1: set_regs($urandom_range(0, 65535), $urandom_range(0, 1440), $urandom_range(0, 65535));
        2: set_regs($urandom_range(32768, 65535), $urandom_range(0, 100),
                    $urandom_range(0, 4000));
        default: set_regs($urandom_range(0, 8191), $urandom_range(0, 300), 65535);
      endcase
      for (int k = 0; k < RAND_PER_BLOCK; k++) begin
        // With the sender never idle, a long hold-off backs up the pipeline.
        if ((blk == 0 || blk == 5) && k == 20) begin
          holds_asked++;
        end
        send_word(pick_angle(), pick_pedal());
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (error_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
